>>> hw/rtl/atf_pkg.sv
// ---------------------------------------------------------------------------
// atf_pkg: shared types and constants of the 4x4 point transform
// Field widths, register map, status codes and the queued item format.
// ---------------------------------------------------------------------------
package atf_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int IO_WIDTH        = 32;
	localparam int NUM_REGS        = 8;
	localparam int REG_WIDTH       = 64;
	localparam int ADDR_WIDTH      = 6;
	localparam int REG_IDX_W       = $clog2(NUM_REGS);
	localparam int QUEUE_DEPTH     = 2;

	// Identity matrix at reset: diagonal coefficients are 1.0 in Q16.16.
	localparam logic [REG_WIDTH-1:0] REG_RESET [NUM_REGS] = '{
		64'h0000_0000_0001_0000,
		64'h0000_0000_0000_0000,
		64'h0001_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0001_0000,
		64'h0000_0000_0000_0000,
		64'h0001_0000_0000_0000
	};

	localparam logic CMD_POINT  = 1'b0;
	localparam logic CMD_VECTOR = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_WZERO = 2'd1,
		ST_SAT   = 2'd2
	} atf_status_t;

	typedef logic [NUM_REGS-1:0][REG_WIDTH-1:0] atf_regs_t;

	// Classified item as it waits in the queue.
	typedef struct packed {
		logic                       vec;
		logic signed [IO_WIDTH-1:0] x;
		logic signed [IO_WIDTH-1:0] y;
		logic signed [IO_WIDTH-1:0] z;
	} atf_item_t;

	// Per-item control carried down the divider pipeline.
	typedef struct packed {
		logic       vec;
		logic       wzero;
		logic       vsat;
		logic [2:0] neg;
	} atf_ctl_t;

endpackage

>>> hw/rtl/atf_if.sv
// ---------------------------------------------------------------------------
// atf_if: stream channels of the 4x4 point transform
// Input channel carries command and coordinates, output channel the results.
// ---------------------------------------------------------------------------
interface atf_in_if import atf_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic                       cmd;
	logic signed [IO_WIDTH-1:0] x_in;
	logic signed [IO_WIDTH-1:0] y_in;
	logic signed [IO_WIDTH-1:0] z_in;

	modport source (output valid, cmd, x_in, y_in, z_in, input ready);
	modport sink (input valid, cmd, x_in, y_in, z_in, output ready);
endinterface

interface atf_out_if import atf_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [IO_WIDTH-1:0] x_out;
	logic signed [IO_WIDTH-1:0] y_out;
	logic signed [IO_WIDTH-1:0] z_out;
	logic [1:0]                 status;

	modport source (output valid, x_out, y_out, z_out, status, input ready);
	modport sink (input valid, x_out, y_out, z_out, status, output ready);
endinterface

>>> hw/rtl/affine_point_transform_4x4.sv
// ---------------------------------------------------------------------------
// affine_point_transform_4x4: homogeneous 4x4 vertex transform
// Fixed-point point/vector transform with perspective divide and saturation.
// ---------------------------------------------------------------------------
// Takes one transaction per clock and returns one result per clock for as
// long as the output side keeps taking them. Point mode (cmd 0) multiplies
// (x,y,z,1) by the matrix and divides x,y,z sums by w; vector mode (cmd 1)
// drops the translation row and shifts the sums down by FRAC_BITS. An item
// passes from the input queue to the multiply register, column sum, sign
// split, COORD_WIDTH + 1 restoring divider stages that each settle one
// quotient bit of all three lanes, and the output register. Results
// saturate to COORD_WIDTH bits and report status 2; a zero w reports
// status 1 with zero coordinates. The matrix sits in eight 64-bit
// registers at byte address 8*i; write them only while no transaction is
// in flight. A stalled output holds the whole datapath while the
// two-entry input queue keeps taking transactions until it fills.
// ---------------------------------------------------------------------------
module affine_point_transform_4x4 import atf_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	atf_in_if.sink                in_ch,
	atf_out_if.source             out_ch,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_WIDTH-1:0] paddr,
	input  logic [REG_WIDTH-1:0]  pwdata,
	output logic [REG_WIDTH-1:0]  prdata,
	output logic                  pready
);

	atf_regs_t regs;
	logic      q_valid;
	atf_item_t q_item;
	logic      pop;

	// Hold the matrix coefficients.
	atf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.regs    (regs)
	);

	// Accept, classify and queue transactions.
	atf_front #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.pop     (pop),
		.q_valid (q_valid),
		.q_item  (q_item)
	);

	// Advance queued items through the transform pipeline.
	atf_back #(
		.COORD_WIDTH (COORD_WIDTH),
		.FRAC_BITS   (FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.regs     (regs),
		.in_valid (q_valid),
		.in_item  (q_item),
		.pop      (pop),
		.out_ch   (out_ch)
	);

endmodule

>>> hw/rtl/atf_cfg.sv
// ---------------------------------------------------------------------------
// atf_cfg: matrix register file
// APB-style write and read of the eight 64-bit coefficient registers.
// ---------------------------------------------------------------------------
module atf_cfg import atf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_WIDTH-1:0] paddr,
	input  logic [REG_WIDTH-1:0]  pwdata,
	output logic [REG_WIDTH-1:0]  prdata,
	output logic                  pready,
	output atf_regs_t             regs
);

	atf_regs_t            regs_q;
	logic [REG_IDX_W-1:0] idx;

	assign idx    = paddr[ADDR_WIDTH-1:3];
	assign pready = 1'b1;
	assign prdata = regs_q[idx];
	assign regs   = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				regs_q[i] <= REG_RESET[i];
			end
		end else if (psel && penable && pwrite && pready) begin
			regs_q[idx] <= pwdata;
		end
	end

endmodule

>>> hw/rtl/atf_front.sv
// ---------------------------------------------------------------------------
// atf_front: input acceptance and item queue
// Classify each transaction, sign-extend coordinates and queue the item.
// ---------------------------------------------------------------------------
module atf_front import atf_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	atf_in_if.sink    in_ch,
	input  logic      pop,
	output logic      q_valid,
	output atf_item_t q_item
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	atf_item_t        mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	atf_item_t        item;
	logic             push;
	logic             take;

	always_comb begin
		item.vec = (in_ch.cmd == CMD_VECTOR);
		item.x   = IO_WIDTH'($signed(in_ch.x_in[COORD_WIDTH-1:0]));
		item.y   = IO_WIDTH'($signed(in_ch.y_in[COORD_WIDTH-1:0]));
		item.z   = IO_WIDTH'($signed(in_ch.z_in[COORD_WIDTH-1:0]));
	end

	assign in_ch.ready = (cnt_q != CNT_W'(QUEUE_DEPTH));
	assign push        = in_ch.valid && in_ch.ready;
	assign q_valid     = (cnt_q != '0);
	assign take        = pop && q_valid;
	assign q_item      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (take) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !take) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (take && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/atf_back.sv
// ---------------------------------------------------------------------------
// atf_back: transform datapath
// Multiply, column sums, pipelined restoring divide, saturation, output reg.
// ---------------------------------------------------------------------------
module atf_back import atf_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  atf_regs_t regs,
	input  logic      in_valid,
	input  atf_item_t in_item,
	output logic      pop,
	atf_out_if.source out_ch
);

	localparam int CW  = COORD_WIDTH;
	localparam int F   = FRAC_BITS;
	localparam int PW  = 2 * CW;
	localparam int TW  = CW + F;
	localparam int SW  = ((PW > TW) ? PW : TW) + 3;
	localparam int MW  = (CW > F) ? CW : F;
	localparam int DW  = SW + MW + 1;
	localparam int QW  = CW + 1;
	localparam int NDS = CW + 1;
	localparam logic [CW-1:0] MIN_V = {1'b1, {(CW - 1){1'b0}}};
	localparam logic [CW-1:0] MAX_V = ~MIN_V;

	logic adv;
	logic out_valid_q;

	logic signed [CW-1:0] coef [4][4];
	logic signed [CW-1:0] src [3];

	// stage 1: products
	logic                 vld_s1;
	logic                 vec_s1;
	logic signed [PW-1:0] prod_s1 [3][4];
	logic signed [TW-1:0] trn_s1 [4];

	// stage 2: column sums
	logic                 vld_s2;
	logic                 vec_s2;
	logic signed [SW-1:0] sum_s2 [4];

	// stage 3 comb
	logic [SW-1:0]        amag [3];
	logic signed [SW-1:0] vsh [3];
	logic [CW-1:0]        vres [3];
	logic [2:0]           vsat_l;
	logic                 wneg;
	logic [SW-1:0]        wmag;
	atf_ctl_t             ctl0;

	// divider pipeline, index 0 is the stage-3 register
	logic          vld_q  [NDS+1];
	logic [DW-1:0] rem_q  [NDS+1][3];
	logic [QW-1:0] quo_q  [NDS+1][3];
	logic [SW-1:0] wmag_q [NDS+1];
	logic [CW-1:0] vout_q [NDS+1][3];
	atf_ctl_t      ctl_q  [NDS+1];

	// final comb
	logic signed [CW-1:0] res [3];
	logic [2:0]           psat;
	atf_status_t          st;

	assign adv          = !out_valid_q || out_ch.ready;
	assign pop          = adv && in_valid;
	assign out_ch.valid = out_valid_q;

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				coef[r][c] = regs[2 * r + (c >> 1)][32 * (c & 1) +: CW];
			end
		end
		src[0] = in_item.x[CW-1:0];
		src[1] = in_item.y[CW-1:0];
		src[2] = in_item.z[CW-1:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vec_s1 <= in_item.vec;
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 4; c++) begin
					prod_s1[r][c] <= src[r] * coef[r][c];
				end
			end
			for (int c = 0; c < 4; c++) begin
				trn_s1[c] <= in_item.vec ? '0 : {coef[3][c], {F{1'b0}}};
			end
			vec_s2 <= vec_s1;
			for (int c = 0; c < 4; c++) begin
				sum_s2[c] <= SW'(prod_s1[0][c]) + SW'(prod_s1[1][c])
					+ SW'(prod_s1[2][c]) + SW'(trn_s1[c]);
			end
		end
	end

	// Split sums into sign and magnitude, finish the vector path here.
	always_comb begin
		wneg = sum_s2[3][SW-1];
		wmag = wneg ? -sum_s2[3] : sum_s2[3];
		for (int l = 0; l < 3; l++) begin
			amag[l]   = sum_s2[l][SW-1] ? -sum_s2[l] : sum_s2[l];
			vsh[l]    = sum_s2[l] >>> F;
			vsat_l[l] = !((&vsh[l][SW-1:CW-1]) || !(|vsh[l][SW-1:CW-1]));
			vres[l]   = vsat_l[l] ? (vsh[l][SW-1] ? MIN_V : MAX_V) : vsh[l][CW-1:0];
			ctl0.neg[l] = sum_s2[l][SW-1] ^ wneg;
		end
		ctl0.vec   = vec_s2;
		ctl0.wzero = !vec_s2 && (sum_s2[3] == '0);
		ctl0.vsat  = |vsat_l;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_q[0]  <= ctl0;
			wmag_q[0] <= wmag;
			for (int l = 0; l < 3; l++) begin
				rem_q[0][l]  <= DW'({amag[l], {F{1'b0}}});
				quo_q[0][l]  <= '0;
				vout_q[0][l] <= vres[l];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			vld_q[0] <= 1'b0;
		end else if (adv) begin
			vld_s1   <= in_valid;
			vld_s2   <= vld_s1;
			vld_q[0] <= vld_s2;
		end
	end

	// One quotient bit per stage, most significant first; the top bit flags overflow.
	for (genvar k = 1; k <= NDS; k++) begin : g_div
		localparam int BIT = NDS - k;
		logic [DW-1:0] dsr;
		logic [2:0]    ge;

		always_comb begin
			dsr = DW'(wmag_q[k-1]) << BIT;
			for (int l = 0; l < 3; l++) begin
				ge[l] = (rem_q[k-1][l] >= dsr);
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				ctl_q[k]  <= ctl_q[k-1];
				wmag_q[k] <= wmag_q[k-1];
				for (int l = 0; l < 3; l++) begin
					rem_q[k][l]  <= ge[l] ? rem_q[k-1][l] - dsr : rem_q[k-1][l];
					quo_q[k][l]  <= quo_q[k-1][l] | (QW'(ge[l]) << BIT);
					vout_q[k][l] <= vout_q[k-1][l];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (adv) begin
				vld_q[k] <= vld_q[k-1];
			end
		end
	end

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			psat[l] = quo_q[NDS][l][CW]
				|| (quo_q[NDS][l][CW-1:0] > (ctl_q[NDS].neg[l] ? MIN_V : MAX_V));
			if (ctl_q[NDS].vec) begin
				res[l] = vout_q[NDS][l];
			end else if (ctl_q[NDS].wzero) begin
				res[l] = '0;
			end else if (psat[l]) begin
				res[l] = ctl_q[NDS].neg[l] ? MIN_V : MAX_V;
			end else begin
				res[l] = ctl_q[NDS].neg[l] ? -quo_q[NDS][l][CW-1:0] : quo_q[NDS][l][CW-1:0];
			end
		end
		if (ctl_q[NDS].vec) begin
			st = ctl_q[NDS].vsat ? ST_SAT : ST_OK;
		end else if (ctl_q[NDS].wzero) begin
			st = ST_WZERO;
		end else begin
			st = (|psat) ? ST_SAT : ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_q[NDS]) begin
			out_ch.x_out  <= IO_WIDTH'(res[0]);
			out_ch.y_out  <= IO_WIDTH'(res[1]);
			out_ch.z_out  <= IO_WIDTH'(res[2]);
			out_ch.status <= st;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= vld_q[NDS];
		end
	end

endmodule

>>> hw/rtl/atf_chk.sv
// ---------------------------------------------------------------------------
// atf_chk: port checker of the 4x4 point transform
// Output handshake and status consistency, bound to the top level.
// ---------------------------------------------------------------------------
module atf_chk import atf_pkg::*; (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic signed [IO_WIDTH-1:0] x_out,
	input logic signed [IO_WIDTH-1:0] y_out,
	input logic signed [IO_WIDTH-1:0] z_out,
	input logic [1:0]                 status
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output transaction dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable({x_out, y_out, z_out, status}))
		else $error("output payload changed while stalled");

	a_wzero_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_WZERO) |-> (x_out == '0) && (y_out == '0) && (z_out == '0))
		else $error("zero w result carries nonzero coordinates");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK) || (status == ST_WZERO) || (status == ST_SAT))
		else $error("undefined status code");

endmodule

bind affine_point_transform_4x4 atf_chk u_atf_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.x_out     (out_ch.x_out),
	.y_out     (out_ch.y_out),
	.z_out     (out_ch.z_out),
	.status    (out_ch.status)
);
